FILE: hdl/scpr_pkg.sv
// Shared constants, control struct and timer helpers for the sound chip port register bank.
// No dependencies; used by every module under hdl/.
package scpr_pkg;

	localparam int DEF_NUM_CHIPS = 5;
	localparam int REGS_PER_CHIP = 16;
	localparam int REG_W         = 4;
	localparam int DATA_W        = 8;
	localparam int PORT_W        = 8;
	localparam int TICK_W        = 22;   // cycle_count / 1024

	localparam logic [PORT_W-1:0] LAST_MAPPED_PORT = 8'h12;
	localparam logic [5:0]        TIMER_CHIP       = 6'd2;
	localparam logic [REG_W-1:0]  TIMER_REG        = 4'd14;
	localparam logic [DATA_W-1:0] IDLE_BYTE        = 8'hFF;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [1:0] OFS_ADDR  = 2'd0;
	localparam logic [1:0] OFS_READ  = 2'd1;
	localparam logic [1:0] OFS_WRITE = 2'd2;

	typedef struct packed {
		logic rd_reg;
		logic wr_reg;
		logic timer_sel;
	} acc_ctl_t;

	// (ticks mod 10): 16^k = 6 (mod 10) for k >= 1, so fold nibbles, then
	// divide the small remainder by 10 through a reciprocal multiply.
	function automatic logic [3:0] timer_index(input logic [TICK_W-1:0] ticks);
		logic [5:0]  hi_sum;
		logic [8:0]  folded;
		logic [16:0] prod;
		logic [5:0]  quot;
		logic [8:0]  rem;
		hi_sum = 6'(ticks[7:4]) + 6'(ticks[11:8]) + 6'(ticks[15:12])
			+ 6'(ticks[19:16]) + 6'(ticks[21:20]);
		folded = 9'(ticks[3:0]) + 9'(hi_sum) * 9'd6;
		prod   = 17'(folded) * 17'd205;   // exact for folded < 1029
		quot   = prod[16:11];
		rem    = folded - 9'(quot) * 9'd10;
		return rem[3:0];
	endfunction

	function automatic logic [DATA_W-1:0] timer_value(input logic [3:0] idx);
		logic [DATA_W-1:0] val;
		case (idx)
			4'd0: val = 8'h00;
			4'd1: val = 8'h01;
			4'd2: val = 8'h02;
			4'd3: val = 8'h03;
			4'd4: val = 8'h04;
			4'd5: val = 8'h09;
			4'd6: val = 8'h0a;
			4'd7: val = 8'h0b;
			4'd8: val = 8'h0a;
			4'd9: val = 8'h0d;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

FILE: hdl/scpr_decode.sv
// Port decode and per-chip address latches.
// Depends on scpr_pkg.
module scpr_decode #(
	parameter int NUM_CHIPS = scpr_pkg::DEF_NUM_CHIPS,
	parameter int CHIP_W    = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1,
	parameter int ADDR_W    = CHIP_W + scpr_pkg::REG_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       vld,
	input  logic                       cmd,
	input  logic [scpr_pkg::PORT_W-1:0] port,
	input  logic [scpr_pkg::DATA_W-1:0] data_in,
	output scpr_pkg::acc_ctl_t         ctl,
	output logic [ADDR_W-1:0]          addr
);
	import scpr_pkg::*;

	logic [REG_W-1:0]  latch_q [NUM_CHIPS];
	logic [5:0]        chip;
	logic [CHIP_W-1:0] chip_sel;
	logic [1:0]        offset;
	logic              mapped;
	logic              latch_wr;
	logic [REG_W-1:0]  reg_sel;

	assign chip     = port[7:2];
	assign chip_sel = chip[CHIP_W-1:0];
	assign offset   = port[1:0];
	assign mapped   = vld && (port <= LAST_MAPPED_PORT) && (chip < 6'(NUM_CHIPS));
	assign reg_sel  = latch_q[chip_sel];
	assign addr     = {chip_sel, reg_sel};

	always_comb begin
		ctl      = '0;
		latch_wr = 1'b0;
		if (mapped) begin
			case (offset)
				OFS_ADDR: begin
					latch_wr = (cmd == CMD_WRITE);
				end
				OFS_READ: begin
					if (cmd == CMD_READ) begin
						ctl.timer_sel = (chip == TIMER_CHIP) && (reg_sel == TIMER_REG);
						ctl.rd_reg    = !ctl.timer_sel;
					end
				end
				OFS_WRITE: begin
					ctl.wr_reg = (cmd == CMD_WRITE);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHIPS; i++) latch_q[i] <= '0;
		end else if (latch_wr) begin
			latch_q[chip_sel] <= data_in[REG_W-1:0];
		end
	end

endmodule

FILE: hdl/scpr_reg_file.sv
// Sound register file: memory with registered read and per-entry valid bits.
// Depends on scpr_pkg.
module scpr_reg_file #(
	parameter int NUM_CHIPS = scpr_pkg::DEF_NUM_CHIPS,
	parameter int CHIP_W    = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1,
	parameter int ADDR_W    = CHIP_W + scpr_pkg::REG_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [ADDR_W-1:0]          addr,
	input  logic [scpr_pkg::DATA_W-1:0] wdata,
	output logic [scpr_pkg::DATA_W-1:0] rdata
);
	import scpr_pkg::*;

	localparam int DEPTH = NUM_CHIPS * REGS_PER_CHIP;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [DATA_W-1:0] mem_q;
	logic              hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[addr] <= wdata;
		mem_q <= mem[addr];
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (wr_en) valid_q[addr] <= 1'b1;
			hit_q <= valid_q[addr];
		end
	end

	assign rdata = hit_q ? mem_q : '0;

endmodule

FILE: hdl/sound_chip_port_register_bank_core.sv
// Top level of the sound chip port register bank: input register, timer read, result stage.
// Depends on scpr_pkg, scpr_decode and scpr_reg_file.
//
//  channel   | signals                                      | transfer
//  ----------+----------------------------------------------+-----------------------------
//  access in | start, busy, cmd, port, data_in, cycle_count | start && !busy at rising clk
//  result    | done, read_data                              | done high for one cycle
//
// One access per cycle; busy never rises. Every access gives one result after
// the input register and then the register file read and latch lookup. arst_n
// clears the address latches and the register file valid bits at once. The
// receiver cannot stall, so nothing holds the pipeline.
module sound_chip_port_register_bank_core #(
	parameter int NUM_CHIPS = scpr_pkg::DEF_NUM_CHIPS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        cmd,
	input  logic [scpr_pkg::PORT_W-1:0]  port,
	input  logic [scpr_pkg::DATA_W-1:0]  data_in,
	input  logic [31:0]                 cycle_count,
	output logic                        done,
	output logic [scpr_pkg::DATA_W-1:0]  read_data
);
	import scpr_pkg::*;

	localparam int CHIP_W = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
	localparam int ADDR_W = CHIP_W + REG_W;

	logic              vld_s1;
	logic              cmd_s1;
	logic [PORT_W-1:0] port_s1;
	logic [DATA_W-1:0] data_s1;
	logic [TICK_W-1:0] ticks_s1;

	logic              vld_s2;
	logic              rd_reg_s2;
	logic              timer_s2;
	logic [DATA_W-1:0] timer_val_s2;

	acc_ctl_t          ctl;
	logic [ADDR_W-1:0] addr;
	logic [DATA_W-1:0] rf_rdata;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1       <= cmd;
		port_s1      <= port;
		data_s1      <= data_in;
		ticks_s1     <= cycle_count[31:10];
		rd_reg_s2    <= ctl.rd_reg;
		timer_s2     <= ctl.timer_sel;
		timer_val_s2 <= timer_value(timer_index(ticks_s1));
	end

	scpr_decode #(
		.NUM_CHIPS(NUM_CHIPS),
		.CHIP_W   (CHIP_W),
		.ADDR_W   (ADDR_W)
	) u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vld_s1),
		.cmd    (cmd_s1),
		.port   (port_s1),
		.data_in(data_s1),
		.ctl    (ctl),
		.addr   (addr)
	);

	scpr_reg_file #(
		.NUM_CHIPS(NUM_CHIPS),
		.CHIP_W   (CHIP_W),
		.ADDR_W   (ADDR_W)
	) u_reg_file (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (ctl.wr_reg),
		.addr  (addr),
		.wdata (data_s1),
		.rdata (rf_rdata)
	);

	assign done = vld_s2;

	always_comb begin
		if (timer_s2) begin
			read_data = timer_val_s2;
		end else if (rd_reg_s2) begin
			read_data = rf_rdata;
		end else begin
			read_data = IDLE_BYTE;
		end
	end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for sound_chip_port_register_bank_core: directed and random port accesses,
// with a tracker class that predicts every result byte. Depends on hdl/scpr_pkg.sv and the RTL.

class reg_bank_tracker;
	logic [3:0] addr_latch [scpr_pkg::DEF_NUM_CHIPS];
	logic [7:0] reg_file [scpr_pkg::DEF_NUM_CHIPS * scpr_pkg::REGS_PER_CHIP];
	logic [7:0] timer_steps [10];
	logic [7:0] due_bytes [$];
	int mismatches;

	function new();
		foreach (addr_latch[i]) addr_latch[i] = '0;
		foreach (reg_file[i]) reg_file[i] = '0;
		timer_steps = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h09, 8'h0a, 8'h0b, 8'h0a, 8'h0d};
		mismatches = 0;
	endfunction

	// Called for every accepted transfer; updates state and queues the byte the block owes.
	function void note_access(logic rd, logic [7:0] p, logic [7:0] d, logic [31:0] cc);
		int unsigned chip;
		int unsigned slot;
		logic [7:0] res;
		chip = p >> 2;
		res = scpr_pkg::IDLE_BYTE;
		if (p <= scpr_pkg::LAST_MAPPED_PORT && chip < scpr_pkg::DEF_NUM_CHIPS) begin
			slot = chip * scpr_pkg::REGS_PER_CHIP + addr_latch[chip];
			if (rd == scpr_pkg::CMD_READ) begin
				if (p[1:0] == scpr_pkg::OFS_READ) begin
					if (chip == scpr_pkg::TIMER_CHIP && addr_latch[chip] == scpr_pkg::TIMER_REG)
						res = timer_steps[(cc >> 10) % 10];
					else
						res = reg_file[slot];
				end
			end else if (p[1:0] == scpr_pkg::OFS_ADDR) begin
				addr_latch[chip] = d[3:0];
			end else if (p[1:0] == scpr_pkg::OFS_WRITE) begin
				reg_file[slot] = d;
			end
		end
		due_bytes.push_back(res);
	endfunction

	function void check_result(logic [7:0] got);
		logic [7:0] want;
		if (due_bytes.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: read_data %02h strobed with no access outstanding", got);
			return;
		end
		want = due_bytes.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: read_data expected %02h, got %02h", want, got);
		end
	endfunction
endclass

module tb_top;
	localparam int CYCLE_LIMIT = 100000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        cmd = scpr_pkg::CMD_WRITE;
	logic [7:0]  port = '0;
	logic [7:0]  data_in = '0;
	logic [31:0] cycle_count = '0;
	logic        done;
	logic [7:0]  read_data;

	reg_bank_tracker tracker;
	int sent_count = 0;
	int sender_idle_pct = 7;
	int tb_cycles = 0;

	sound_chip_port_register_bank_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.port(port),
		.data_in(data_in),
		.cycle_count(cycle_count),
		.done(done),
		.read_data(read_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Outputs and inputs are sampled at the edge, before this edge's updates land.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				tracker.check_result(read_data);
			if (start && !busy)
				tracker.note_access(cmd, port, data_in, cycle_count);
		end
	end

	always @(posedge clk) begin
		tb_cycles++;
		if (tb_cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Presents one access and returns at the edge where it transfers.
	task automatic send_access(input logic rd, input logic [7:0] p, input logic [7:0] d,
			input logic [31:0] cc);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= rd;
		port <= p;
		data_in <= d;
		cycle_count <= cc;
		do @(posedge clk); while (busy);
		sent_count++;
	endtask

	function automatic logic [31:0] pick_cycles();
		return ($urandom_range(1) == 0) ? $urandom() : 32'($urandom_range(0, 20479));
	endfunction

	// Mostly a latch write followed by register traffic on the same chip; the rest is noise.
	task automatic random_burst();
		int unsigned chip;
		int unsigned n;
		logic [3:0] reg_sel;
		logic [7:0] base;
		if ($urandom_range(99) < 75) begin
			chip = $urandom_range(scpr_pkg::DEF_NUM_CHIPS - 1);
			base = 8'(chip * 4);
			reg_sel = ($urandom_range(3) == 0) ? scpr_pkg::TIMER_REG : 4'($urandom_range(15));
			send_access(scpr_pkg::CMD_WRITE, base + 8'(scpr_pkg::OFS_ADDR),
				{4'($urandom_range(15)), reg_sel}, $urandom());
			n = $urandom_range(1, 4);
			repeat (n) begin
				case ($urandom_range(9))
					0: send_access(1'($urandom_range(1)), base + 8'($urandom_range(3)),
						8'($urandom_range(255)), pick_cycles());
					1, 2, 3, 4: send_access(scpr_pkg::CMD_READ, base + 8'(scpr_pkg::OFS_READ),
						8'($urandom_range(255)), pick_cycles());
					default: send_access(scpr_pkg::CMD_WRITE, base + 8'(scpr_pkg::OFS_WRITE),
						8'($urandom_range(255)), pick_cycles());
				endcase
			end
		end else begin
			send_access(1'($urandom_range(1)),
				($urandom_range(1) == 0) ? 8'($urandom_range(31)) : 8'($urandom_range(255)),
				8'($urandom_range(255)), $urandom());
		end
	endtask

	initial begin
		tracker = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset contents, latch masking, timer chip, top mapped chip, unmapped ports
		send_access(scpr_pkg::CMD_READ, 8'h01, 8'hFF, 32'h0);
		send_access(scpr_pkg::CMD_WRITE, 8'h00, 8'hF5, 32'h0);
		send_access(scpr_pkg::CMD_WRITE, 8'h02, 8'hAA, 32'h0);
		send_access(scpr_pkg::CMD_READ, 8'h01, 8'h00, 32'hFFFF_FFFF);
		send_access(scpr_pkg::CMD_WRITE, 8'h00, 8'h0F, 32'h0);
		send_access(scpr_pkg::CMD_WRITE, 8'h02, 8'hFF, 32'h0);
		send_access(scpr_pkg::CMD_READ, 8'h01, 8'h00, 32'h0);
		send_access(scpr_pkg::CMD_WRITE, 8'h08, 8'h0E, 32'h0);
		send_access(scpr_pkg::CMD_WRITE, 8'h0A, 8'h55, 32'h0);
		send_access(scpr_pkg::CMD_READ, 8'h09, 8'h00, 32'h0);
		send_access(scpr_pkg::CMD_READ, 8'h09, 8'h00, 32'hFFFF_FFFF);
		send_access(scpr_pkg::CMD_READ, 8'h09, 8'h00, 32'd5120);
		send_access(scpr_pkg::CMD_READ, 8'h09, 8'h00, 32'd10239);
		send_access(scpr_pkg::CMD_WRITE, 8'h08, 8'h0D, 32'h0);
		send_access(scpr_pkg::CMD_READ, 8'h09, 8'h00, 32'd3000);
		send_access(scpr_pkg::CMD_WRITE, 8'h10, 8'h03, 32'h0);
		send_access(scpr_pkg::CMD_WRITE, 8'h12, 8'h80, 32'h0);
		send_access(scpr_pkg::CMD_READ, 8'h11, 8'h00, 32'h0);
		send_access(scpr_pkg::CMD_WRITE, 8'h13, 8'h12, 32'h0);
		send_access(scpr_pkg::CMD_READ, 8'h13, 8'h00, 32'h0);
		send_access(scpr_pkg::CMD_READ, 8'hFF, 8'h00, 32'h0);
		send_access(scpr_pkg::CMD_WRITE, 8'hFE, 8'h77, 32'h0);
		send_access(scpr_pkg::CMD_READ, 8'h03, 8'h00, 32'h0);
		send_access(scpr_pkg::CMD_WRITE, 8'h01, 8'h33, 32'h0);
		send_access(scpr_pkg::CMD_READ, 8'h00, 8'h00, 32'h0);
		send_access(scpr_pkg::CMD_READ, 8'h02, 8'h00, 32'h0);

		while (sent_count < 480) random_burst();
		sender_idle_pct = 54;
		while (sent_count < 960) random_burst();
		sender_idle_pct = 0;
		while (sent_count < 1450) random_burst();

		start <= 1'b0;
		while (tracker.due_bytes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		if (tracker.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
